[hw/rtl/pcw_pkg.sv]
// Shared types, constants and saturation helpers for the pooled covariance whitening block.
package pcw_pkg;

  localparam int PCW_MAX_SAMPLES = 64;
  localparam int PCW_FRAC_BITS   = 16;

  localparam int VTX_W = 18;
  localparam int CRD_W = 32;
  localparam int WHT_W = 24;

  // Shared divider operand widths.
  localparam int NUM_W = 64;
  localparam int DEN_W = 32;

  // Off-diagonal factors at or above this magnitude cannot give a positive pivot.
  localparam logic [63:0] R_LIMIT = 64'd1 << 30;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_FEW = 2'd1,
    ST_NPD = 2'd2,
    ST_OVF = 2'd3
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    logic signed [23:0] r;
    if (v > 64'sd8388607) begin
      r = 24'sh7fffff;
    end else if (v < -64'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] negsat32(input logic signed [31:0] v);
    logic signed [31:0] r;
    if (v == 32'sh80000000) begin
      r = 32'sh7fffffff;
    end else begin
      r = -v;
    end
    return r;
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    logic [63:0] r;
    if (v < 0) begin
      r = 64'(-v);
    end else begin
      r = 64'(v);
    end
    return r;
  endfunction

endpackage

[hw/rtl/pcw_in_if.sv]
// Sample input channel: valid/ready handshake with one 3-D sample per transfer.
interface pcw_in_if;
  logic                            valid;
  logic                            ready;
  logic [pcw_pkg::VTX_W-1:0]       vertex_index;
  logic                            group;
  logic signed [pcw_pkg::CRD_W-1:0] coord_x;
  logic signed [pcw_pkg::CRD_W-1:0] coord_y;
  logic signed [pcw_pkg::CRD_W-1:0] coord_z;
  logic                            last_sample;

  modport source (output valid, vertex_index, group, coord_x, coord_y, coord_z, last_sample,
                  input ready);
  modport sink (input valid, vertex_index, group, coord_x, coord_y, coord_z, last_sample,
                output ready);
endinterface

[hw/rtl/pcw_out_if.sv]
// Result output channel: valid/ready handshake with one whitened sample per transfer.
interface pcw_out_if;
  logic                             valid;
  logic                             ready;
  logic [pcw_pkg::VTX_W-1:0]        vertex_out;
  logic                             group_out;
  logic signed [pcw_pkg::WHT_W-1:0] white_0;
  logic signed [pcw_pkg::WHT_W-1:0] white_1;
  logic signed [pcw_pkg::WHT_W-1:0] white_2;
  pcw_pkg::status_t                 status;
  logic                             last_result;

  modport source (output valid, vertex_out, group_out, white_0, white_1, white_2, status,
                  last_result, input ready);
  modport sink (input valid, vertex_out, group_out, white_0, white_1, white_2, status,
                last_result, output ready);
endinterface

[hw/rtl/pcw_ram.sv]
// Generic single-port-write, registered-read RAM.
module pcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/pcw_div.sv]
// Iterative signed divider, one quotient bit per cycle, rounds to nearest with ties away from zero.
module pcw_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [pcw_pkg::NUM_W-1:0]   num,
  input  logic [pcw_pkg::DEN_W-1:0]          den,
  output logic                               done,
  output logic signed [pcw_pkg::NUM_W-1:0]   quo
);
  import pcw_pkg::*;

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_RND, D_SGN} dstate_t;

  dstate_t                     state;
  logic [NUM_W-1:0]            mag;
  logic [DEN_W-1:0]            rem;
  logic [DEN_W-1:0]            dv;
  logic                        neg;
  logic [$clog2(NUM_W)-1:0]    cnt;
  logic [DEN_W:0]              rem_sh;
  logic                        ge;

  assign rem_sh = {rem, mag[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dv};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= D_IDLE;
    end else begin
      unique case (state)
        D_IDLE: begin
          if (start) begin
            mag   <= abs64(num);
            neg   <= num[NUM_W-1];
            dv    <= den;
            rem   <= '0;
            cnt   <= '0;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          rem <= ge ? DEN_W'(rem_sh - {1'b0, dv}) : rem_sh[DEN_W-1:0];
          mag <= {mag[NUM_W-2:0], ge};
          cnt <= cnt + 1'b1;
          if (cnt == $clog2(NUM_W)'(NUM_W - 1)) begin
            state <= D_RND;
          end
        end
        D_RND: begin
          if ({rem, 1'b0} >= {1'b0, dv}) begin
            mag <= mag + 1'b1;
          end
          state <= D_SGN;
        end
        D_SGN: begin
          quo   <= neg ? -$signed(mag) : $signed(mag);
          done  <= 1'b1;
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end
endmodule

[hw/rtl/pcw_sqrt.sv]
// Iterative integer square root, two radicand bits per cycle, floor result.
module pcw_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] arg,
  output logic        done,
  output logic [31:0] root
);
  typedef enum logic [0:0] {Q_IDLE, Q_RUN} qstate_t;

  qstate_t     state;
  logic [63:0] v;
  logic [33:0] rem;
  logic [31:0] acc;
  logic [4:0]  cnt;
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        ge;

  assign rem_sh = {rem, v[63:62]};
  assign trial  = {2'b00, acc, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= Q_IDLE;
    end else begin
      unique case (state)
        Q_IDLE: begin
          if (start) begin
            v     <= arg;
            rem   <= '0;
            acc   <= '0;
            cnt   <= '0;
            state <= Q_RUN;
          end
        end
        Q_RUN: begin
          rem <= ge ? 34'(rem_sh - trial) : rem_sh[33:0];
          acc <= {acc[30:0], ge};
          v   <= {v[61:0], 2'b00};
          cnt <= cnt + 1'b1;
          if (cnt == 5'd31) begin
            root  <= {acc[30:0], ge};
            done  <= 1'b1;
            state <= Q_IDLE;
          end
        end
        default: state <= Q_IDLE;
      endcase
    end
  end
endmodule

[hw/rtl/pooled_covariance_whitening.sv]
// Top level: sample store, sequencer and shared multiplier of the pooled covariance whitener.
//
// Samples of one vertex arrive on the "samples" channel, one per transfer, tagged with a group
// (0 or 1); ready stays high while the block is collecting.
// The transfer that carries last_sample ends the vertex: ready drops and the sequencer computes
// the two group means, the pooled covariance, its 3x3 Cholesky factor and the inverse factor,
// then replays every stored sample, centered and whitened, on the "results" channel in input
// order, with last_result on the final one. A failure gives a single result with a nonzero status.
// The 64-step divider sets most of the compute time; the single 32x32 multiplier sets the
// per-sample passes.
// Only one result is held at a time: when the receiver stalls, the result register keeps its
// value and the sequencer waits. Ready returns once the final result of the vertex transfers.
// Synchronous reset returns to collecting with empty counts and sums; the sample store has no
// reset and only entries written for the current vertex are read back.
module pooled_covariance_whitening #(
  parameter int MAX_SAMPLES = pcw_pkg::PCW_MAX_SAMPLES,
  parameter int FRAC_BITS   = pcw_pkg::PCW_FRAC_BITS
) (
  input logic     clk,
  input logic     rst,
  pcw_in_if.sink  samples,
  pcw_out_if.source results
);
  import pcw_pkg::*;

  localparam int AW    = $clog2(MAX_SAMPLES);
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = CRD_W + CNT_W;
  localparam int RAM_W = 1 + 3 * CRD_W;

  localparam logic signed [63:0] HALF_Q   = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] ONE_SQ   = 64'sd1 <<< (2 * FRAC_BITS);
  localparam logic [63:0]        COV_LIM  = 64'd1 << (60 - FRAC_BITS);

  typedef enum logic [4:0] {
    S_LOAD, S_CHECK, S_MEAN, S_MEAN_W, S_COV_RD, S_COV_D, S_COV_MUL, S_COV_END,
    S_CDIV, S_CDIV_W, S_SC_ISSUE, S_SC_WAIT, S_SC_USE, S_WH_RD, S_WH_D, S_WH_MUL,
    S_WH_END, S_WH_OUT, S_ERR, S_OUT_WAIT
  } state_t;

  // Scalar steps of the factoring and inversion, in order.
  typedef enum logic [4:0] {
    U_R00, U_R01, U_R02, U_P1, U_R11, U_Q12, U_R12, U_P2A, U_P2B, U_R22,
    U_T0, U_T3, U_T5, U_A1, U_T1, U_A4, U_T4, U_A2, U_B2, U_T2
  } uop_t;

  state_t state;
  uop_t   uop;

  // Collection state.
  logic [CNT_W-1:0]        cnt0, cnt1;
  logic signed [SUM_W-1:0] sums [6];
  logic                    ovf;
  logic [VTX_W-1:0]        vlatch;
  logic [CNT_W-1:0]        total, total_m1, total_m2;

  // Compute state.
  logic signed [31:0] mean [6];
  logic signed [63:0] acc [6];
  logic signed [63:0] cov [6];
  logic [31:0]        r00, r11, r22;
  logic signed [31:0] r01, r02, r12;
  logic signed [31:0] inv [6];
  logic signed [63:0] tmp;
  logic signed [31:0] dv [3];
  logic signed [63:0] w0, w1, w2;
  logic               gk;
  logic [AW-1:0]      k;
  logic [2:0]         idx, jx;
  status_t            err_code;
  logic               fin;

  // Shared multiplier with rounding stage; v/tag follow accumulating products.
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod, prnd;
  logic               v1, v2;
  logic [3:0]         tag1, tag2;

  // Store.
  logic             ram_we;
  logic [RAM_W-1:0] ram_rdata;
  logic signed [31:0] rd_x, rd_y, rd_z;
  logic             rd_g;
  logic signed [31:0] d_x, d_y, d_z;

  // Divider and root units.
  logic               div_start, div_done;
  logic signed [63:0] div_num, div_quo;
  logic [31:0]        div_den;
  logic               sq_start, sq_done;
  logic [63:0]        sq_arg;
  logic [31:0]        sq_root;
  logic               uop_div, uop_sqrt;

  // Output register.
  logic               out_valid;
  logic               out_group;
  logic signed [23:0] out_w0, out_w1, out_w2;
  status_t            out_status;
  logic               out_last;

  logic signed [63:0] cmp_val;

  assign total    = cnt0 + cnt1;
  assign total_m1 = total - 1'b1;
  assign total_m2 = total - CNT_W'(2);

  assign samples.ready       = (state == S_LOAD);
  assign results.valid       = out_valid;
  assign results.vertex_out  = vlatch;
  assign results.group_out   = out_group;
  assign results.white_0     = out_w0;
  assign results.white_1     = out_w1;
  assign results.white_2     = out_w2;
  assign results.status      = out_status;
  assign results.last_result = out_last;

  assign ram_we = samples.valid && samples.ready && (total < CNT_W'(MAX_SAMPLES));

  pcw_ram #(.WIDTH(RAM_W), .DEPTH(MAX_SAMPLES)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (total[AW-1:0]),
    .wdata ({samples.group, samples.coord_x, samples.coord_y, samples.coord_z}),
    .raddr (k),
    .rdata (ram_rdata)
  );

  assign rd_g = ram_rdata[RAM_W-1];
  assign rd_x = ram_rdata[3*CRD_W-1:2*CRD_W];
  assign rd_y = ram_rdata[2*CRD_W-1:CRD_W];
  assign rd_z = ram_rdata[CRD_W-1:0];

  // Deviation from the mean of the sample's own group.
  assign d_x = sat32(64'(rd_x) - 64'(rd_g ? mean[3] : mean[0]));
  assign d_y = sat32(64'(rd_y) - 64'(rd_g ? mean[4] : mean[1]));
  assign d_z = sat32(64'(rd_z) - 64'(rd_g ? mean[5] : mean[2]));

  pcw_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  pcw_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .arg   (sq_arg),
    .done  (sq_done),
    .root  (sq_root)
  );

  always_comb begin
    uop_div  = (uop == U_R01) || (uop == U_R02) || (uop == U_R12) ||
               (uop == U_T0) || (uop == U_T3) || (uop == U_T5);
    uop_sqrt = (uop == U_R00) || (uop == U_R11) || (uop == U_R22);
  end

  // Operand selection for the shared units.
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    sq_start  = 1'b0;
    sq_arg    = '0;
    unique case (state)
      S_MEAN: begin
        div_start = 1'b1;
        div_num   = 64'(sums[idx]);
        div_den   = (idx >= 3'd3) ? 32'(cnt1) : 32'(cnt0);
      end
      S_CDIV: begin
        div_start = 1'b1;
        div_num   = acc[idx];
        div_den   = 32'(total_m2);
      end
      S_COV_MUL: begin
        unique case (jx)
          3'd0: begin mul_a = dv[0]; mul_b = dv[0]; end
          3'd1: begin mul_a = dv[0]; mul_b = dv[1]; end
          3'd2: begin mul_a = dv[0]; mul_b = dv[2]; end
          3'd3: begin mul_a = dv[1]; mul_b = dv[1]; end
          3'd4: begin mul_a = dv[1]; mul_b = dv[2]; end
          default: begin mul_a = dv[2]; mul_b = dv[2]; end
        endcase
      end
      S_WH_MUL: begin
        unique case (jx)
          3'd0: begin mul_a = inv[0]; mul_b = dv[0]; end
          3'd1: begin mul_a = inv[1]; mul_b = dv[0]; end
          3'd2: begin mul_a = inv[3]; mul_b = dv[1]; end
          3'd3: begin mul_a = inv[2]; mul_b = dv[0]; end
          3'd4: begin mul_a = inv[4]; mul_b = dv[1]; end
          default: begin mul_a = inv[5]; mul_b = dv[2]; end
        endcase
      end
      S_SC_ISSUE: begin
        div_start = uop_div;
        sq_start  = uop_sqrt;
        unique case (uop)
          U_R00: sq_arg = 64'(cov[0] <<< FRAC_BITS);
          U_R01: begin div_num = cov[1] <<< FRAC_BITS; div_den = r00; end
          U_R02: begin div_num = cov[2] <<< FRAC_BITS; div_den = r00; end
          U_P1:  begin mul_a = r01; mul_b = r01; end
          U_R11: sq_arg = 64'(tmp <<< FRAC_BITS);
          U_Q12: begin mul_a = r01; mul_b = r02; end
          U_R12: begin div_num = tmp <<< FRAC_BITS; div_den = r11; end
          U_P2A: begin mul_a = r02; mul_b = r02; end
          U_P2B: begin mul_a = r12; mul_b = r12; end
          U_R22: sq_arg = 64'(tmp <<< FRAC_BITS);
          U_T0:  begin div_num = ONE_SQ; div_den = r00; end
          U_T3:  begin div_num = ONE_SQ; div_den = r11; end
          U_T5:  begin div_num = ONE_SQ; div_den = r22; end
          U_A1:  begin mul_a = inv[0]; mul_b = r01; end
          U_T1:  begin mul_a = tmp[31:0]; mul_b = inv[3]; end
          U_A4:  begin mul_a = inv[3]; mul_b = r12; end
          U_T4:  begin mul_a = tmp[31:0]; mul_b = inv[5]; end
          U_A2:  begin mul_a = inv[0]; mul_b = r02; end
          U_B2:  begin mul_a = inv[1]; mul_b = r12; end
          default: begin mul_a = tmp[31:0]; mul_b = inv[5]; end
        endcase
      end
      default: ;
    endcase
  end

  // Candidate pivot or partial value for the scalar steps that subtract a rounded product.
  always_comb begin
    unique case (uop)
      U_P1:    cmp_val = cov[3] - prnd;
      U_Q12:   cmp_val = cov[4] - prnd;
      U_P2A:   cmp_val = cov[5] - prnd;
      default: cmp_val = tmp - prnd;
    endcase
  end

  always_ff @(posedge clk) begin
    // Multiplier pipeline runs every cycle; tags mark products to accumulate.
    prod <= 64'(mul_a) * 64'(mul_b);
    prnd <= (prod + HALF_Q) >>> FRAC_BITS;
    v1   <= 1'b0;
    tag1 <= '0;
    v2   <= v1;
    tag2 <= tag1;
    if (v2) begin
      if (!tag2[3]) begin
        acc[tag2[2:0]] <= acc[tag2[2:0]] + prnd;
      end else if (tag2[2:0] == 3'd0) begin
        w0 <= w0 + prnd;
      end else if (tag2[2:0] <= 3'd2) begin
        w1 <= w1 + prnd;
      end else begin
        w2 <= w2 + prnd;
      end
    end

    if (rst) begin
      state     <= S_LOAD;
      uop       <= U_R00;
      cnt0      <= '0;
      cnt1      <= '0;
      for (int i = 0; i < 6; i++) begin
        sums[i] <= '0;
      end
      ovf       <= 1'b0;
      vlatch    <= '0;
      out_valid <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      k         <= '0;
      idx       <= '0;
      jx        <= '0;
      fin       <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (samples.valid) begin
            if (total == '0 && !ovf) begin
              vlatch <= samples.vertex_index;
            end
            if (total < CNT_W'(MAX_SAMPLES)) begin
              if (samples.group) begin
                cnt1    <= cnt1 + 1'b1;
                sums[3] <= sums[3] + SUM_W'(samples.coord_x);
                sums[4] <= sums[4] + SUM_W'(samples.coord_y);
                sums[5] <= sums[5] + SUM_W'(samples.coord_z);
              end else begin
                cnt0    <= cnt0 + 1'b1;
                sums[0] <= sums[0] + SUM_W'(samples.coord_x);
                sums[1] <= sums[1] + SUM_W'(samples.coord_y);
                sums[2] <= sums[2] + SUM_W'(samples.coord_z);
              end
            end else begin
              ovf <= 1'b1;
            end
            if (samples.last_sample) begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          idx <= '0;
          priority if (ovf) begin
            err_code <= ST_OVF;
            state    <= S_ERR;
          end else if (cnt0 == '0 || cnt1 == '0 || total < CNT_W'(5)) begin
            err_code <= ST_FEW;
            state    <= S_ERR;
          end else begin
            state <= S_MEAN;
          end
        end
        S_MEAN: state <= S_MEAN_W;
        S_MEAN_W: begin
          if (div_done) begin
            mean[idx] <= div_quo[31:0];
            if (idx == 3'd5) begin
              for (int i = 0; i < 6; i++) begin
                acc[i] <= '0;
              end
              k     <= '0;
              state <= S_COV_RD;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_MEAN;
            end
          end
        end
        S_COV_RD: state <= S_COV_D;
        S_COV_D: begin
          dv[0] <= d_x;
          dv[1] <= d_y;
          dv[2] <= d_z;
          jx    <= '0;
          state <= S_COV_MUL;
        end
        S_COV_MUL: begin
          v1   <= 1'b1;
          tag1 <= {1'b0, jx};
          if (jx == 3'd5) begin
            if (k == total_m1[AW-1:0]) begin
              state <= S_COV_END;
            end else begin
              k     <= k + 1'b1;
              state <= S_COV_RD;
            end
          end else begin
            jx <= jx + 1'b1;
          end
        end
        S_COV_END: begin
          if (!v1 && !v2) begin
            idx   <= '0;
            state <= S_CDIV;
          end
        end
        S_CDIV: state <= S_CDIV_W;
        S_CDIV_W: begin
          if (div_done) begin
            cov[idx] <= div_quo;
            priority if (abs64(div_quo) >= COV_LIM) begin
              err_code <= ST_OVF;
              state    <= S_ERR;
            end else if (idx == 3'd5) begin
              if (cov[0] <= 0) begin
                err_code <= ST_NPD;
                state    <= S_ERR;
              end else begin
                uop   <= U_R00;
                state <= S_SC_ISSUE;
              end
            end else begin
              idx   <= idx + 1'b1;
              state <= S_CDIV;
            end
          end
        end
        S_SC_ISSUE: state <= S_SC_WAIT;
        S_SC_WAIT: begin
          // A product is registered, then rounded, before S_SC_USE; the divider and root unit report done.
          if ((!uop_div && !uop_sqrt) || div_done || sq_done) begin
            state <= S_SC_USE;
          end
        end
        S_SC_USE: begin
          uop   <= uop_t'(uop + 1'b1);
          state <= S_SC_ISSUE;
          unique case (uop)
            U_R00: r00 <= sq_root;
            U_R01: begin
              r01 <= div_quo[31:0];
              if (abs64(div_quo) >= R_LIMIT) begin
                err_code <= ST_NPD;
                state    <= S_ERR;
              end
            end
            U_R02: begin
              r02 <= div_quo[31:0];
              if (abs64(div_quo) >= R_LIMIT) begin
                err_code <= ST_NPD;
                state    <= S_ERR;
              end
            end
            U_P1, U_P2B: begin
              tmp <= cmp_val;
              if (cmp_val <= 0) begin
                err_code <= ST_NPD;
                state    <= S_ERR;
              end
            end
            U_R11: r11 <= sq_root;
            U_Q12, U_P2A: tmp <= cmp_val;
            U_R12: begin
              r12 <= div_quo[31:0];
              if (abs64(div_quo) >= R_LIMIT) begin
                err_code <= ST_NPD;
                state    <= S_ERR;
              end
            end
            U_R22: r22 <= sq_root;
            U_T0:  inv[0] <= sat32(div_quo);
            U_T3:  inv[3] <= sat32(div_quo);
            U_T5:  inv[5] <= sat32(div_quo);
            U_A1, U_A4, U_A2: tmp <= 64'(sat32(prnd));
            U_T1:  inv[1] <= negsat32(sat32(prnd));
            U_T4:  inv[4] <= negsat32(sat32(prnd));
            U_B2:  tmp <= 64'(sat32(64'($signed(tmp[31:0])) + 64'(sat32(prnd))));
            default: begin
              inv[2] <= negsat32(sat32(prnd));
              k      <= '0;
              state  <= S_WH_RD;
            end
          endcase
        end
        S_WH_RD: state <= S_WH_D;
        S_WH_D: begin
          dv[0] <= d_x;
          dv[1] <= d_y;
          dv[2] <= d_z;
          gk    <= rd_g;
          w0    <= '0;
          w1    <= '0;
          w2    <= '0;
          jx    <= '0;
          state <= S_WH_MUL;
        end
        S_WH_MUL: begin
          v1   <= 1'b1;
          tag1 <= {1'b1, jx};
          if (jx == 3'd5) begin
            state <= S_WH_END;
          end else begin
            jx <= jx + 1'b1;
          end
        end
        S_WH_END: begin
          if (!v1 && !v2) begin
            state <= S_WH_OUT;
          end
        end
        S_WH_OUT: begin
          out_valid  <= 1'b1;
          out_group  <= gk;
          out_w0     <= sat24(w0);
          out_w1     <= sat24(w1);
          out_w2     <= sat24(w2);
          out_status <= ST_OK;
          out_last   <= (k == total_m1[AW-1:0]);
          fin        <= (k == total_m1[AW-1:0]);
          state      <= S_OUT_WAIT;
        end
        S_ERR: begin
          out_valid  <= 1'b1;
          out_group  <= 1'b0;
          out_w0     <= '0;
          out_w1     <= '0;
          out_w2     <= '0;
          out_status <= err_code;
          out_last   <= 1'b1;
          fin        <= 1'b1;
          state      <= S_OUT_WAIT;
        end
        S_OUT_WAIT: begin
          if (results.ready) begin
            out_valid <= 1'b0;
            if (fin) begin
              // Vertex done: clear the collection state for the next one.
              cnt0 <= '0;
              cnt1 <= '0;
              for (int i = 0; i < 6; i++) begin
                sums[i] <= '0;
              end
              ovf   <= 1'b0;
              state <= S_LOAD;
            end else begin
              k     <= k + 1'b1;
              state <= S_WH_RD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // While collecting, no result is pending.
  a_ready_no_result: assert property (@(posedge clk) disable iff (rst)
    samples.ready |-> !results.valid)
    else $error("sample ready while a result is pending");

  // An error result carries zero components and closes the vertex.
  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.status != ST_OK) |->
      (results.white_0 == '0 && results.white_1 == '0 && results.white_2 == '0 &&
       results.last_result && !results.group_out))
    else $error("malformed error result");

  // The multiplier pipeline is drained whenever new samples are taken.
  a_pipe_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) |-> (!v1 && !v2))
    else $error("products in flight while collecting");

  // The final result of a vertex returns the block to collecting with empty counts.
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.ready && results.last_result) |=>
      (state == S_LOAD && cnt0 == '0 && cnt1 == '0 && !ovf))
    else $error("vertex state not cleared after final result");

endmodule
